// ----- hdl/dhcprop_pkg.sv -----
// ============================================================================
// DHCP reply option parser - shared definitions
// Header constants, option codes, the per-message snapshot and result types.
// ============================================================================
package dhcprop_pkg;

    localparam int DEF_MAX_MESSAGE_BYTES = 548;

    // Fixed header layout
    localparam int HDR_BYTES        = 240;
    localparam int POS_OP           = 0;
    localparam int POS_HTYPE        = 1;
    localparam int POS_HLEN         = 2;
    localparam int POS_XID_END      = 7;
    localparam int POS_YIADDR_END   = 19;
    localparam int POS_COOKIE_END   = 239;

    localparam logic [7:0]  OP_BOOTREPLY = 8'd2;
    localparam logic [7:0]  HTYPE_ETH    = 8'd1;
    localparam logic [7:0]  HLEN_ETH     = 8'd6;
    localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;

    // Option codes
    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_MASK     = 8'd1;
    localparam logic [7:0] OPT_ROUTER   = 8'd3;
    localparam logic [7:0] OPT_DNS      = 8'd6;
    localparam logic [7:0] OPT_BCAST    = 8'd28;
    localparam logic [7:0] OPT_STATIC   = 8'd33;
    localparam logic [7:0] OPT_LEASE    = 8'd51;
    localparam logic [7:0] OPT_OVERLOAD = 8'd52;
    localparam logic [7:0] OPT_TYPE     = 8'd53;
    localparam logic [7:0] OPT_SERVER   = 8'd54;
    localparam logic [7:0] OPT_T1       = 8'd58;
    localparam logic [7:0] OPT_T2       = 8'd59;
    localparam logic [7:0] OPT_END      = 8'd255;

    // Message types that carry an offered address
    localparam logic [7:0] MSG_OFFER = 8'd2;
    localparam logic [7:0] MSG_ACK   = 8'd5;

    // Loopback host address, never valid as an offered address
    localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;

    // Captured word slots
    localparam int NUM_WORDS = 10;
    localparam int W_YIADDR  = 0;
    localparam int W_MASK    = 1;
    localparam int W_ROUTER  = 2;
    localparam int W_DNS1    = 3;
    localparam int W_DNS2    = 4;
    localparam int W_BCAST   = 5;
    localparam int W_SERVER  = 6;
    localparam int W_LEASE   = 7;
    localparam int W_T1      = 8;
    localparam int W_T2      = 9;

    // floor(x / 7) = (x * RECIP7) >> RECIP7_SHIFT for any x below 2^34
    localparam logic [34:0] RECIP7       = 35'h4_9249_2493;
    localparam logic [17:0] RECIP7_LO    = RECIP7[17:0];
    localparam logic [16:0] RECIP7_HI    = RECIP7[34:18];
    localparam int          RECIP7_SHIFT = 37;

    // State of one message at its last byte
    typedef struct packed {
        logic                           reject;
        logic [7:0]                     msg_type;
        logic [NUM_WORDS-1:0][31:0]     words;
    } snap_t;

    // One result transaction
    typedef struct packed {
        logic        status;
        logic [7:0]  message_type;
        logic [31:0] your_address;
        logic [31:0] subnet_mask;
        logic [31:0] router_addr;
        logic [31:0] dns_primary;
        logic [31:0] dns_secondary;
        logic [31:0] broadcast_addr;
        logic [31:0] server_id;
        logic [31:0] lease_seconds;
        logic [31:0] renewal_seconds;
        logic [31:0] rebinding_seconds;
    } result_t;

endpackage

// ----- hdl/dhcprop_parser.sv -----
// ============================================================================
// DHCP reply option parser - byte parser
// Walks the fixed header and the TLV options one byte per transaction and
// presents the message snapshot on the last byte.
// ============================================================================
module dhcprop_parser #(
    parameter int MAX_MESSAGE_BYTES = dhcprop_pkg::DEF_MAX_MESSAGE_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         expected_xid,
    input  logic                byte_fire,
    input  logic [7:0]          msg_byte,
    input  logic                last_byte,
    output logic                snap_valid,
    output dhcprop_pkg::snap_t  snap
);
    import dhcprop_pkg::*;

    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);
    localparam logic [POS_W-1:0] POS_HDR = POS_W'(HDR_BYTES);

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_CODE   = 4'b0010,
        PH_LEN    = 4'b0100,
        PH_DATA   = 4'b1000
    } phase_t;

    logic [POS_W-1:0]           pos_reg, pos_next;
    phase_t                     phase_reg, phase_next;
    logic [7:0]                 code_reg, code_next;
    logic [7:0]                 rem_reg, rem_next;
    logic [7:0]                 off_reg, off_next;
    logic                       reject_reg, reject_next;
    logic                       end_reg, end_next;
    logic                       ovl_reg, ovl_next;
    logic [31:0]                xid_reg, xid_next;
    logic [NUM_WORDS-1:0][31:0] words_reg, words_next;
    logic [7:0]                 type_reg, type_next;
    logic                       len_ok;

    always_comb
    begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        code_next   = code_reg;
        rem_next    = rem_reg;
        off_next    = off_reg;
        reject_next = reject_reg;
        end_next    = end_reg;
        ovl_next    = ovl_reg;
        xid_next    = xid_reg;
        words_next  = words_reg;
        type_next   = type_reg;
        len_ok      = 1'b1;

        if (pos_reg < POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg < POS_HDR)
            begin
                xid_next = {xid_reg[23:0], msg_byte};
                if (pos_reg == POS_W'(POS_OP) && msg_byte != OP_BOOTREPLY)
                    reject_next = 1'b1;
                if (pos_reg == POS_W'(POS_HTYPE) && msg_byte != HTYPE_ETH)
                    reject_next = 1'b1;
                if (pos_reg == POS_W'(POS_HLEN) && msg_byte != HLEN_ETH)
                    reject_next = 1'b1;
                if (pos_reg == POS_W'(POS_XID_END) && xid_next != expected_xid)
                    reject_next = 1'b1;
                if (pos_reg == POS_W'(POS_YIADDR_END))
                    words_next[W_YIADDR] = xid_next;
                if (pos_reg == POS_W'(POS_COOKIE_END))
                begin
                    if (xid_next != MAGIC_COOKIE)
                        reject_next = 1'b1;
                    phase_next = PH_CODE;
                end
            end
            else if (!reject_reg && !end_reg)
            begin
                unique case (phase_reg)
                    PH_CODE:
                    begin
                        if (msg_byte == OPT_END)
                            end_next = 1'b1;
                        else if (msg_byte != OPT_PAD)
                        begin
                            code_next  = msg_byte;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        unique case (code_reg) inside
                            OPT_MASK, OPT_BCAST, OPT_LEASE, OPT_SERVER, OPT_T1, OPT_T2:
                                len_ok = (msg_byte == 8'd4);
                            OPT_ROUTER, OPT_DNS:
                                len_ok = (msg_byte != 8'd0) && (msg_byte[1:0] == 2'b00);
                            OPT_STATIC:
                                len_ok = (msg_byte != 8'd0) && (msg_byte[2:0] == 3'b000);
                            OPT_TYPE:
                                len_ok = (msg_byte == 8'd1);
                            OPT_OVERLOAD:
                            begin
                                len_ok = (msg_byte == 8'd1) && !ovl_reg;
                                if (len_ok)
                                    ovl_next = 1'b1;
                            end
                            default:
                                len_ok = 1'b1;
                        endcase
                        if (!len_ok)
                            reject_next = 1'b1;
                        else
                        begin
                            rem_next   = msg_byte;
                            off_next   = 8'd0;
                            phase_next = (msg_byte != 8'd0) ? PH_DATA : PH_CODE;
                        end
                    end
                    PH_DATA:
                    begin
                        // Shift the first word of a captured option into its slot; DNS also fills a second slot
                        unique case (code_reg) inside
                            OPT_MASK:
                                if (off_reg[7:2] == '0)
                                    words_next[W_MASK] = {words_reg[W_MASK][23:0], msg_byte};
                            OPT_ROUTER:
                                if (off_reg[7:2] == '0)
                                    words_next[W_ROUTER] = {words_reg[W_ROUTER][23:0], msg_byte};
                            OPT_DNS:
                                if (off_reg[7:2] == '0)
                                    words_next[W_DNS1] = {words_reg[W_DNS1][23:0], msg_byte};
                                else if (off_reg[7:3] == '0)
                                    words_next[W_DNS2] = {words_reg[W_DNS2][23:0], msg_byte};
                            OPT_BCAST:
                                if (off_reg[7:2] == '0)
                                    words_next[W_BCAST] = {words_reg[W_BCAST][23:0], msg_byte};
                            OPT_SERVER:
                                if (off_reg[7:2] == '0)
                                    words_next[W_SERVER] = {words_reg[W_SERVER][23:0], msg_byte};
                            OPT_LEASE:
                                if (off_reg[7:2] == '0)
                                    words_next[W_LEASE] = {words_reg[W_LEASE][23:0], msg_byte};
                            OPT_T1:
                                if (off_reg[7:2] == '0)
                                    words_next[W_T1] = {words_reg[W_T1][23:0], msg_byte};
                            OPT_T2:
                                if (off_reg[7:2] == '0)
                                    words_next[W_T2] = {words_reg[W_T2][23:0], msg_byte};
                            OPT_TYPE:
                                type_next = msg_byte;
                            default:
                                type_next = type_reg;
                        endcase
                        off_next = off_reg + 8'd1;
                        rem_next = rem_reg - 8'd1;
                        if (rem_next == 8'd0)
                            phase_next = PH_CODE;
                    end
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end

        // Short message, or one that stops inside an option, is rejected
        snap.reject   = reject_next || (pos_next < POS_HDR) ||
                        (!end_next && (phase_next == PH_LEN || phase_next == PH_DATA));
        snap.msg_type = type_next;
        snap.words    = words_next;
    end

    assign snap_valid = byte_fire && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= PH_HEADER;
            code_reg   <= '0;
            rem_reg    <= '0;
            off_reg    <= '0;
            reject_reg <= 1'b0;
            end_reg    <= 1'b0;
            ovl_reg    <= 1'b0;
            xid_reg    <= '0;
            words_reg  <= '0;
            type_reg   <= '0;
        end
        else if (byte_fire)
        begin
            if (last_byte)
            begin
                // Start over for the next message
                pos_reg    <= '0;
                phase_reg  <= PH_HEADER;
                code_reg   <= '0;
                rem_reg    <= '0;
                off_reg    <= '0;
                reject_reg <= 1'b0;
                end_reg    <= 1'b0;
                ovl_reg    <= 1'b0;
                xid_reg    <= '0;
                words_reg  <= '0;
                type_reg   <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                phase_reg  <= phase_next;
                code_reg   <= code_next;
                rem_reg    <= rem_next;
                off_reg    <= off_next;
                reject_reg <= reject_next;
                end_reg    <= end_next;
                ovl_reg    <= ovl_next;
                xid_reg    <= xid_next;
                words_reg  <= words_next;
                type_reg   <= type_next;
            end
        end
    end

endmodule

// ----- hdl/dhcprop_lease.sv -----
// ============================================================================
// DHCP reply option parser - result pipeline
// Checks the offered address, applies the T1/T2 defaults and holds the
// result in the output register.
// ============================================================================
module dhcprop_lease (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  snap_valid,
    input  dhcprop_pkg::snap_t    snap,
    output logic                  snap_ready,
    output logic                  res_valid,
    input  logic                  res_ready,
    output dhcprop_pkg::result_t  res
);
    import dhcprop_pkg::*;

    // Stage 1: snapshot
    logic        s1_valid_reg;
    snap_t       s1_reg;

    // Stage 2: defaults applied
    logic        s2_valid_reg;
    logic        s2_bad_reg, s2_bad_next;
    snap_t       s2_reg;
    logic [31:0] s2_t1_reg, s2_t1_next;
    logic [31:0] s2_t2_reg, s2_t2_next;

    // Stage 3: partial products of 4*T2 / 7
    logic        s3_valid_reg;
    logic        s3_bad_reg;
    snap_t       s3_reg;
    logic [31:0] s3_t1_reg, s3_t2_reg;
    logic        s3_sel_reg, s3_sel_next;
    logic [51:0] s3_plo_reg, s3_plo_next;
    logic [50:0] s3_phi_reg, s3_phi_next;

    // Output
    logic        out_valid_reg;
    result_t     out_reg, out_next;

    logic        out_free, s3_free, s2_free, s1_free;
    logic [31:0] lease2, t1_in, t2_in;
    logic [34:0] lease_x7;
    logic [33:0] t2_x4;
    logic [68:0] quot_sum;
    logic [31:0] t1_final;
    logic        yi_bad;

    // Each stage advances when the one after it is empty or moving
    assign out_free   = !out_valid_reg || res_ready;
    assign s3_free    = !s3_valid_reg || out_free;
    assign s2_free    = !s2_valid_reg || s3_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign snap_ready = s1_free;

    // Stage 2 logic
    always_comb
    begin
        lease2   = s1_reg.words[W_LEASE];
        t1_in    = s1_reg.words[W_T1];
        t2_in    = s1_reg.words[W_T2];
        lease_x7 = {lease2, 3'b000} - {3'b000, lease2};
        yi_bad   = (s1_reg.words[W_YIADDR][31:29] == 3'b111) ||
                   (s1_reg.words[W_YIADDR] == 32'd0) ||
                   (s1_reg.words[W_YIADDR] == LOOPBACK_ADDR);
        s2_bad_next = s1_reg.reject ||
                      ((s1_reg.msg_type == MSG_OFFER || s1_reg.msg_type == MSG_ACK) && yi_bad);
        s2_t1_next  = (t1_in == 32'd0 || lease2 <= t1_in) ? {1'b0, lease2[31:1]} : t1_in;
        s2_t2_next  = (t2_in == 32'd0 || lease2 <= t2_in) ? lease_x7[34:3] : t2_in;
    end

    // Stage 3 logic
    assign t2_x4       = {s2_t2_reg, 2'b00};
    assign s3_sel_next = (s2_t2_reg <= s2_t1_reg);
    assign s3_plo_next = t2_x4 * RECIP7_LO;
    assign s3_phi_next = t2_x4 * RECIP7_HI;

    // Output logic
    always_comb
    begin
        quot_sum = {s3_phi_reg, 18'b0} + {17'b0, s3_plo_reg};
        t1_final = s3_sel_reg ? quot_sum[RECIP7_SHIFT +: 32] : s3_t1_reg;
        out_next = '0;
        if (s3_bad_reg)
            out_next.status = 1'b1;
        else
        begin
            out_next.message_type      = s3_reg.msg_type;
            out_next.your_address      = s3_reg.words[W_YIADDR];
            out_next.subnet_mask       = s3_reg.words[W_MASK];
            out_next.router_addr       = s3_reg.words[W_ROUTER];
            out_next.dns_primary       = s3_reg.words[W_DNS1];
            out_next.dns_secondary     = s3_reg.words[W_DNS2];
            out_next.broadcast_addr    = s3_reg.words[W_BCAST];
            out_next.server_id         = s3_reg.words[W_SERVER];
            out_next.lease_seconds     = s3_reg.words[W_LEASE];
            out_next.renewal_seconds   = t1_final;
            out_next.rebinding_seconds = s3_t2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= snap_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (out_free)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && snap_valid)
            s1_reg <= snap;
        if (s2_free && s1_valid_reg)
        begin
            s2_bad_reg <= s2_bad_next;
            s2_reg     <= s1_reg;
            s2_t1_reg  <= s2_t1_next;
            s2_t2_reg  <= s2_t2_next;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_bad_reg <= s2_bad_reg;
            s3_reg     <= s2_reg;
            s3_t1_reg  <= s2_t1_reg;
            s3_t2_reg  <= s2_t2_reg;
            s3_sel_reg <= s3_sel_next;
            s3_plo_reg <= s3_plo_next;
            s3_phi_reg <= s3_phi_next;
        end
        if (out_free && s3_valid_reg)
            out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ----- hdl/dhcp_reply_option_parser.sv -----
// ============================================================================
// DHCP reply option parser - top level
// Parses a DHCP reply byte stream and gives one lease result per message.
// ============================================================================
// Usage:
//   s_axis carries the reply one byte per transaction, starting at the op
//   byte; s_axis_tlast marks the final byte. Bytes are taken one per cycle
//   while s_axis_tready is high.
//   xid_wr_en/xid_wr_data load the expected transaction id; write it only
//   between messages.
//   m_axis gives one result transaction per message. The last byte closes
//   the snapshot register, then a stage applies the T1/T2 defaults, a stage
//   forms the 4*T2/7 partial products, and the output register holds the
//   result.
//   Throughput: one byte per cycle while m_axis keeps up; a message as short
//   as one byte still yields its result, so results can follow each other
//   every cycle. When m_axis_tready is low the result stages fill behind the
//   output register; s_axis_tready drops only when all four stages hold
//   results. Reset clears the parser, empties the result stages and loads an
//   expected transaction id of zero.
// ============================================================================
module dhcp_reply_option_parser #(
    parameter int MAX_MESSAGE_BYTES = dhcprop_pkg::DEF_MAX_MESSAGE_BYTES
) (
    input  logic         clk,
    input  logic         rst_n,
    // Transaction id register
    input  logic         xid_wr_en,
    input  logic [31:0]  xid_wr_data,
    // Reply bytes
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] msg_byte
    input  logic         s_axis_tlast,   // last_byte
    // Results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [335:0] m_axis_tdata    // [0] status, [8:1] message_type,
                                         // [40:9] your_address,
                                         // [72:41] subnet_mask,
                                         // [104:73] router_addr,
                                         // [136:105] dns_primary,
                                         // [168:137] dns_secondary,
                                         // [200:169] broadcast_addr,
                                         // [232:201] server_id,
                                         // [264:233] lease_seconds,
                                         // [296:265] renewal_seconds,
                                         // [328:297] rebinding_seconds,
                                         // [335:329] zero
);
    import dhcprop_pkg::*;

    logic [31:0] expected_xid_reg;
    logic        byte_fire;
    logic        snap_valid;
    snap_t       snap;
    result_t     res;

    // Hold the expected transaction id until the next write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_xid_reg <= '0;
        else if (xid_wr_en)
            expected_xid_reg <= xid_wr_data;
    end

    assign byte_fire = s_axis_tvalid && s_axis_tready;

    // Header and option walk, one byte per transaction
    dhcprop_parser #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .expected_xid (expected_xid_reg),
        .byte_fire    (byte_fire),
        .msg_byte     (s_axis_tdata),
        .last_byte    (s_axis_tlast),
        .snap_valid   (snap_valid),
        .snap         (snap)
    );

    // Address check, lease defaults and output register
    dhcprop_lease u_lease (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (s_axis_tready),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    // Pack the result, first field in the lowest bits
    assign m_axis_tdata = {7'b0,
                           res.rebinding_seconds,
                           res.renewal_seconds,
                           res.lease_seconds,
                           res.server_id,
                           res.broadcast_addr,
                           res.dns_secondary,
                           res.dns_primary,
                           res.router_addr,
                           res.subnet_mask,
                           res.your_address,
                           res.message_type,
                           res.status};

endmodule
